@@ hdl/msq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_pkg: shared types and constants of the sample capture queue
// Payload structs, command and mode codes, sequencer states and the
// operations of the shared pointer unit.
// ----------------------------------------------------------------------------
package msq_pkg;

  localparam int SAMPLE_W   = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int CAP_W      = 7;
  localparam int CFG_DATA_W = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_GET  = 2'd1,
    CMD_ZERO = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_UNSET = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_FILL  = 2'd2,
    MODE_RING  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RD_DATA   = 2'd0,
    RD_EMPTY  = 2'd1,
    RD_NO_NEW = 2'd2
  } rd_status_t;

  typedef enum logic [0:0] {
    REG_QUEUE_MODE = 1'b0,
    REG_CAPACITY   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_ZERO,
    S_RD,
    S_SEND
  } state_t;

  typedef enum logic [1:0] {
    ALU_ADD_MOD = 2'd0,
    ALU_SUB_MOD = 2'd1,
    ALU_SUB     = 2'd2
  } alu_op_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [SAMPLE_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic [IDX_W-1:0]    entry_index;
    logic [CNT_W-1:0]    entry_count;
    logic                overflow_flag;
    rd_status_t          read_status;
    logic                last_of_run;
  } out_t;

endpackage

@@ hdl/msq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module msq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/msq_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_alu: shared modular pointer unit
// One modular adder/subtractor with a compare, used for the write and read
// pointer updates of the queue, each modular result wrapped once at the modulus.
// ----------------------------------------------------------------------------
module msq_alu #(
  parameter int W = 7
) (
  input  msq_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  input  logic [W-1:0]     m,
  output logic [W-1:0]     y,
  output logic             ge
);

  logic [W:0] sum;
  logic [W:0] sum_wrap;
  logic [W:0] sub_wrap;

  always_comb begin
    sum      = {1'b0, a} + {1'b0, b};
    sum_wrap = sum - {1'b0, m};
    sub_wrap = {1'b0, a} + {1'b0, m} - {1'b0, b};
    ge       = (a >= b);
    case (op)
      msq_pkg::ALU_ADD_MOD: y = (sum >= {1'b0, m}) ? sum_wrap[W-1:0] : sum[W-1:0];
      msq_pkg::ALU_SUB_MOD: y = ge ? (a - b) : sub_wrap[W-1:0];
      msq_pkg::ALU_SUB:     y = a - b;
      default:              y = a;
    endcase
  end

endmodule

@@ hdl/monitor_sample_capture_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monitor_sample_capture_queue: capture buffer for 64-bit sample words
// Push, get and zero commands over a sample store with three fill modes.
// ----------------------------------------------------------------------------
// A push is taken directly in the idle state, so pushes can stream at one per
// cycle while no result waits stalled in the output register and no register
// is written. A get is accepted and then returns each entry by a store read
// followed by the load of the output register, which waits while the output
// is stalled; a get that only reports an empty buffer or no new sample loads
// that status when it is accepted. A zero command sweeps the store, one entry
// per cycle, over all STORE_DEPTH entries, and no item is taken meanwhile. No
// item is taken in the cycle of a register write. After a register write the
// write pointer is brought back into range by repeated subtraction of the
// capacity before the next item is taken. The write and read pointer updates
// share one modular add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
module monitor_sample_capture_queue #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  msq_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output msq_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  msq_pkg::cfg_reg_t                   cfg_idx,
  input  logic [msq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CW    = $clog2(STORE_DEPTH + 1);
  localparam int CAP_W = msq_pkg::CAP_W;
  localparam int IDX_W = msq_pkg::IDX_W;
  localparam int CNT_W = msq_pkg::CNT_W;
  localparam int SW    = msq_pkg::SAMPLE_W;

  msq_pkg::state_t   state_r, state_nxt;
  msq_pkg::mode_t    mode_r;
  logic [CAP_W-1:0]  cap_r;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     wpr_r, wpr_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic              new_r, new_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     zaddr_r, zaddr_nxt;
  logic              out_valid_r, out_valid_nxt;
  msq_pkg::out_t     out_data_r, out_data_nxt;

  msq_pkg::mode_t    mode_eff;
  logic [CW-1:0]     cap_eff;
  logic [CW-1:0]     n_cnt;
  logic [CW:0]       fill_inc;
  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic              get_no_new;
  logic              get_empty;
  logic              get_status;
  logic              run_last;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [SW-1:0]     ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [SW-1:0]     ram_rdata;

  msq_pkg::alu_op_t  alu_op;
  logic [CW-1:0]     alu_a;
  logic [CW-1:0]     alu_b;
  logic [CW-1:0]     alu_y;
  logic              alu_ge;

  msq_ram #(
    .WIDTH(SW),
    .DEPTH(STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  msq_alu #(
    .W(CW)
  ) u_alu (
    .op(alu_op),
    .a (alu_a),
    .b (alu_b),
    .m (cap_eff),
    .y (alu_y),
    .ge(alu_ge)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= msq_pkg::MODE_CLEAR;
      cap_r  <= msq_pkg::CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        msq_pkg::REG_QUEUE_MODE: mode_r <= msq_pkg::mode_t'(cfg_wdata[1:0]);
        msq_pkg::REG_CAPACITY:   cap_r  <= cfg_wdata;
        default:                 mode_r <= mode_r;
      endcase
    end
  end

  always_comb begin
    mode_eff = (mode_r == msq_pkg::MODE_UNSET) ? msq_pkg::MODE_CLEAR : mode_r;
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (cap_r > CAP_W'(STORE_DEPTH)) begin
      cap_eff = CW'(STORE_DEPTH);
    end else begin
      cap_eff = cap_r[CW-1:0];
    end
    n_cnt      = (fill_r < cap_eff) ? fill_r : cap_eff;
    fill_inc   = {1'b0, fill_r} + (CW+1)'(1);
    in_stall   = (state_r != msq_pkg::S_IDLE) || (out_valid_r && out_stall) || cfg_we;
    in_acc     = in_valid && !in_stall;
    out_free   = !out_valid_r || !out_stall;
    get_no_new = (mode_eff == msq_pkg::MODE_CLEAR) && !new_r;
    get_empty  = (n_cnt == '0);
    get_status = get_no_new || get_empty;
    run_last   = ((CW'(idx_r) + CW'(1)) == n_cnt);
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msq_pkg::S_IDLE: begin
        if (cfg_we) begin
          state_nxt = msq_pkg::S_NORM;
        end else if (in_acc) begin
          case (in_data.cmd)
            msq_pkg::CMD_GET:  state_nxt = get_status ? msq_pkg::S_IDLE : msq_pkg::S_RD;
            msq_pkg::CMD_ZERO: state_nxt = msq_pkg::S_ZERO;
            default:           state_nxt = msq_pkg::S_IDLE;
          endcase
        end
      end
      msq_pkg::S_NORM: begin
        if (!cfg_we && !alu_ge) begin
          state_nxt = msq_pkg::S_IDLE;
        end
      end
      msq_pkg::S_ZERO: begin
        if (zaddr_r == AW'(STORE_DEPTH - 1)) begin
          state_nxt = msq_pkg::S_IDLE;
        end
      end
      msq_pkg::S_RD: begin
        state_nxt = msq_pkg::S_SEND;
      end
      msq_pkg::S_SEND: begin
        if (out_free) begin
          state_nxt = run_last ? msq_pkg::S_IDLE : msq_pkg::S_RD;
        end
      end
      default: state_nxt = msq_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates.
  always_comb begin
    wp_nxt       = wp_r;
    wpr_nxt      = wpr_r;
    fill_nxt     = fill_r;
    ovf_nxt      = ovf_r;
    new_nxt      = new_r;
    pos_nxt      = pos_r;
    idx_nxt      = idx_r;
    zaddr_nxt    = zaddr_r;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    ram_we       = 1'b0;
    ram_waddr    = wpr_r;
    ram_wdata    = in_data.sample_in;
    ram_re       = 1'b0;
    ram_raddr    = pos_r;
    alu_op       = msq_pkg::ALU_ADD_MOD;
    alu_a        = CW'(wpr_r);
    alu_b        = CW'(1);
    case (state_r)
      msq_pkg::S_IDLE: begin
        if (cfg_we) begin
          // The stored pointer is rescaled against the new capacity.
          wpr_nxt = wp_r;
        end else if (in_acc) begin
          case (in_data.cmd)
            msq_pkg::CMD_PUSH: begin
              new_nxt = 1'b1;
              if (mode_eff == msq_pkg::MODE_RING) begin
                ram_we    = 1'b1;
                ram_waddr = wpr_r;
                wp_nxt    = alu_y[AW-1:0];
                wpr_nxt   = alu_y[AW-1:0];
                if (fill_r < cap_eff) begin
                  fill_nxt = fill_inc[CW-1:0];
                end
                ovf_nxt = ovf_r | (fill_inc >= {1'b0, cap_eff});
              end else if (fill_r < cap_eff) begin
                ram_we    = 1'b1;
                ram_waddr = fill_r[AW-1:0];
                alu_a     = fill_r;
                fill_nxt  = fill_inc[CW-1:0];
                wp_nxt    = alu_y[AW-1:0];
                wpr_nxt   = alu_y[AW-1:0];
                ovf_nxt   = ovf_r | (fill_inc >= {1'b0, cap_eff});
              end
            end
            msq_pkg::CMD_GET: begin
              alu_op = msq_pkg::ALU_SUB_MOD;
              alu_b  = n_cnt;
              if (get_status) begin
                out_load                   = 1'b1;
                out_data_nxt.sample_out    = '0;
                out_data_nxt.entry_index   = '0;
                out_data_nxt.entry_count   = '0;
                out_data_nxt.overflow_flag = ovf_r;
                out_data_nxt.read_status   = get_no_new ? msq_pkg::RD_NO_NEW
                                                        : msq_pkg::RD_EMPTY;
                out_data_nxt.last_of_run   = 1'b1;
                if (!get_no_new) begin
                  if (mode_eff == msq_pkg::MODE_CLEAR) begin
                    fill_nxt = '0;
                    wp_nxt   = '0;
                    wpr_nxt  = '0;
                    ovf_nxt  = 1'b0;
                    new_nxt  = 1'b0;
                  end else if (mode_eff == msq_pkg::MODE_RING) begin
                    new_nxt = 1'b0;
                  end
                end
              end else begin
                // The run starts n entries behind the write pointer.
                pos_nxt = alu_y[AW-1:0];
                idx_nxt = '0;
              end
            end
            msq_pkg::CMD_ZERO: begin
              fill_nxt  = '0;
              wp_nxt    = '0;
              wpr_nxt   = '0;
              ovf_nxt   = 1'b0;
              new_nxt   = 1'b0;
              zaddr_nxt = '0;
            end
            default: begin
              new_nxt = new_r;
            end
          endcase
        end
      end
      msq_pkg::S_NORM: begin
        alu_op = msq_pkg::ALU_SUB;
        alu_b  = cap_eff;
        if (cfg_we) begin
          wpr_nxt = wp_r;
        end else if (alu_ge) begin
          wpr_nxt = alu_y[AW-1:0];
        end
      end
      msq_pkg::S_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = zaddr_r;
        ram_wdata = '0;
        zaddr_nxt = zaddr_r + AW'(1);
      end
      msq_pkg::S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_r;
      end
      msq_pkg::S_SEND: begin
        alu_a = CW'(pos_r);
        if (out_free) begin
          out_load                   = 1'b1;
          out_data_nxt.sample_out    = ram_rdata;
          out_data_nxt.entry_index   = IDX_W'(idx_r);
          out_data_nxt.entry_count   = CNT_W'(n_cnt);
          out_data_nxt.overflow_flag = ovf_r;
          out_data_nxt.read_status   = msq_pkg::RD_DATA;
          out_data_nxt.last_of_run   = run_last;
          pos_nxt                    = alu_y[AW-1:0];
          idx_nxt                    = idx_r + AW'(1);
          if (run_last) begin
            if (mode_eff == msq_pkg::MODE_CLEAR) begin
              fill_nxt = '0;
              wp_nxt   = '0;
              wpr_nxt  = '0;
              ovf_nxt  = 1'b0;
              new_nxt  = 1'b0;
            end else if (mode_eff == msq_pkg::MODE_RING) begin
              new_nxt = 1'b0;
            end
          end
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msq_pkg::S_IDLE;
      wp_r        <= '0;
      wpr_r       <= '0;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      new_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      wpr_r       <= wpr_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      new_r       <= new_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    zaddr_r    <= zaddr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A zero transfer clears the counters and starts the store sweep.
  a_zero_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_we && in_data.cmd == msq_pkg::CMD_ZERO)
      |=> (state_r == msq_pkg::S_ZERO && fill_r == '0 && !ovf_r))
    else $error("zero command did not start the clearing sweep");

  // The final entry of a run returns the sequencer to idle.
  a_run_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msq_pkg::S_SEND && out_free && run_last)
      |=> (state_r == msq_pkg::S_IDLE))
    else $error("get run did not end after its last entry");

  // While the output register is blocked the read run holds its place.
  a_send_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msq_pkg::S_SEND && !out_free)
      |=> (state_r == msq_pkg::S_SEND && $stable(pos_r) && $stable(idx_r)))
    else $error("read run advanced while the output was stalled");

  // A data result always lies inside a non-empty run.
  a_data_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.read_status == msq_pkg::RD_DATA)
      |-> (out_data_r.entry_count != '0 &&
           CNT_W'(out_data_r.entry_index) < out_data_r.entry_count))
    else $error("data result outside of its read run");

endmodule
